[src/pqrs_pkg.sv]
// pqrs_pkg: depths, field widths, command and status codes, entry type
// and the command/status structs shared by the controller and the datapath
// no dependencies
`timescale 1ns / 1ps

package pqrs_pkg;

    localparam int QUEUE_DEPTH = 5;
    localparam int STACK_DEPTH = 3;

    localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SIDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SCNT_W = $clog2(STACK_DEPTH + 1);

    localparam int MAX_PAIRS = ((QUEUE_DEPTH / 2) > (STACK_DEPTH / 2)) ?
                               (QUEUE_DEPTH / 2) : (STACK_DEPTH / 2);
    localparam int PAIR_W = $clog2(MAX_PAIRS + 1);

    localparam int CMD_W    = 3;
    localparam int KIND_W   = 2;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 3;
    localparam int QLVL_W   = 3;
    localparam int SLVL_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PLAY    = 3'd0,
        CMD_RESERVE = 3'd1,
        CMD_USE     = 3'd2,
        CMD_SWAP    = 3'd3,
        CMD_UNDO    = 3'd4,
        CMD_REVERSE = 3'd5,
        CMD_INSERT  = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_QUEUE_EMPTY = 3'd1,
        ST_STACK_FULL  = 3'd2,
        ST_STACK_EMPTY = 3'd3,
        ST_NO_UNDO     = 3'd4,
        ST_QUEUE_FULL  = 3'd5
    } status_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
    } entry_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic rev_rd;
        logic rev_xfer;
        logic rev_wr;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_reverse;
        logic rev_more;
    } dp_status_t;

endpackage

[src/pqrs_ctrl.sv]
// pqrs_ctrl: command sequencer for the piece queue, drives the datapath
// depends on pqrs_pkg
`timescale 1ns / 1ps

module pqrs_ctrl
    import pqrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t dst,
    output ctrl_cmd_t  ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_REV_RD,
        S_REV_XFER,
        S_REV_WR,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        ctl          = '0;
        ctl.load_in  = (state_reg == S_IDLE) && in_valid;
        ctl.exec     = (state_reg == S_EXEC) && !dst.is_reverse;
        ctl.rev_rd   = (state_reg == S_REV_RD);
        ctl.rev_xfer = (state_reg == S_REV_XFER);
        ctl.rev_wr   = (state_reg == S_REV_WR);
        ctl.load_out = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (dst.is_reverse && dst.rev_more)
                begin
                    state_next = S_REV_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_REV_RD:   state_next = S_REV_XFER;
            S_REV_XFER: state_next = S_REV_WR;
            S_REV_WR:   state_next = S_EXEC;
            S_FINISH:
            begin
                if (ctl.load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (ctl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // a result is never loaded over one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // a transfer in is always followed by the execute step
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EXEC))
        else $error("execute step skipped");

endmodule

[src/pqrs_dp.sv]
// pqrs_dp: queue and stack stores, pointers, undo record and result register
// depends on pqrs_pkg, steered by pqrs_ctrl
`timescale 1ns / 1ps

module pqrs_dp
    import pqrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CMD_W-1:0]    command,
    input  logic [KIND_W-1:0]   new_kind,
    input  logic [ID_W-1:0]     new_id,
    input  ctrl_cmd_t           ctl,
    output dp_status_t          dst,
    output logic [STATUS_W-1:0] status,
    output logic [KIND_W-1:0]   piece_kind,
    output logic [ID_W-1:0]     piece_id,
    output logic [QLVL_W-1:0]   queue_level,
    output logic [SLVL_W-1:0]   stack_level,
    output logic                undo_ready
);

    localparam logic [QCNT_W-1:0] QFULL  = QCNT_W'(QUEUE_DEPTH);
    localparam logic [SCNT_W-1:0] SFULL  = SCNT_W'(STACK_DEPTH);
    localparam logic [QIDX_W-1:0] QLAST  = QIDX_W'(QUEUE_DEPTH - 1);

    // circular position: head plus offset, offset at most the depth
    function automatic logic [QIDX_W-1:0] slot(input logic [QIDX_W-1:0] head,
                                               input logic [QCNT_W-1:0] off);
        logic [QCNT_W:0] sum;
        sum = (QCNT_W+1)'(head) + (QCNT_W+1)'(off);
        if (sum >= (QCNT_W+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (QCNT_W+1)'(QUEUE_DEPTH);
        end
        return QIDX_W'(sum);
    endfunction

    entry_t              q_mem [QUEUE_DEPTH];
    entry_t              s_mem [STACK_DEPTH];

    logic [QIDX_W-1:0]   head_reg, head_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [SCNT_W-1:0]   sc_reg, sc_next;
    logic                undo_valid_reg, undo_valid_next;
    logic [PAIR_W-1:0]   pair_reg, pair_next;
    entry_t              undo_entry_reg, undo_entry_next;
    cmd_t                cmd_reg;
    entry_t              fresh_reg;
    status_t             status_reg, status_next;
    entry_t              piece_reg, piece_next;
    entry_t              tq_reg;
    entry_t              ts_reg;

    logic [STATUS_W-1:0] status_out_reg;
    entry_t              piece_out_reg;
    logic [QLVL_W-1:0]   qlvl_out_reg;
    logic [SLVL_W-1:0]   slvl_out_reg;
    logic                undo_out_reg;

    logic [QIDX_W-1:0]   q_raddr, q_waddr;
    entry_t              q_rdata, q_wdata;
    logic                q_we;
    logic [SIDX_W-1:0]   s_raddr, s_waddr;
    entry_t              s_rdata, s_wdata;
    logic                s_we;

    logic [QCNT_W-1:0]   q_far;
    logic [SCNT_W-1:0]   s_far;
    logic [QCNT_W-1:0]   count_mid;
    logic                q_act, s_act;

    assign q_far = count_reg - QCNT_W'(1) - QCNT_W'(pair_reg);
    assign s_far = sc_reg - SCNT_W'(1) - SCNT_W'(pair_reg);
    assign q_act = (QCNT_W'(pair_reg) < (count_reg >> 1));
    assign s_act = (SCNT_W'(pair_reg) < (sc_reg >> 1));

    assign dst.is_reverse = (cmd_reg == CMD_REVERSE);
    assign dst.rev_more   = q_act || s_act;

    always_comb
    begin
        q_raddr = head_reg;
        s_raddr = SIDX_W'(sc_reg - SCNT_W'(1));
        if (ctl.rev_rd)
        begin
            q_raddr = slot(head_reg, QCNT_W'(pair_reg));
            s_raddr = SIDX_W'(pair_reg);
        end
        else if (ctl.rev_xfer)
        begin
            q_raddr = slot(head_reg, q_far);
            s_raddr = SIDX_W'(s_far);
        end
    end

    assign q_rdata = q_mem[q_raddr];
    assign s_rdata = s_mem[s_raddr];

    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        sc_next         = sc_reg;
        undo_valid_next = undo_valid_reg;
        undo_entry_next = undo_entry_reg;
        pair_next       = pair_reg;
        status_next     = status_reg;
        piece_next      = piece_reg;
        count_mid       = count_reg;
        q_we            = 1'b0;
        q_waddr         = head_reg;
        q_wdata         = fresh_reg;
        s_we            = 1'b0;
        s_waddr         = SIDX_W'(sc_reg);
        s_wdata         = q_rdata;

        if (ctl.load_in)
        begin
            status_next = ST_OK;
            piece_next  = '0;
            pair_next   = '0;
        end

        if (ctl.exec)
        begin
            case (cmd_reg)
                CMD_PLAY, CMD_RESERVE:
                begin
                    if ((cmd_reg == CMD_RESERVE) && (sc_reg == SFULL))
                    begin
                        status_next = ST_STACK_FULL;
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_QUEUE_EMPTY;
                    end
                    else
                    begin
                        piece_next = q_rdata;
                        head_next  = (head_reg == QLAST) ? '0 : head_reg + QIDX_W'(1);
                        count_mid  = count_reg - QCNT_W'(1);
                        if (cmd_reg == CMD_PLAY)
                        begin
                            undo_entry_next = q_rdata;
                            undo_valid_next = 1'b1;
                        end
                        else
                        begin
                            s_we    = 1'b1;
                            sc_next = sc_reg + SCNT_W'(1);
                        end
                    end
                    // refill from the supplied entry; freed slot sits at head + count
                    count_next = count_mid;
                    if (count_mid < QFULL)
                    begin
                        q_we       = 1'b1;
                        q_waddr    = slot(head_reg, count_reg);
                        count_next = count_mid + QCNT_W'(1);
                    end
                end
                CMD_USE:
                begin
                    if (sc_reg == '0)
                    begin
                        status_next = ST_STACK_EMPTY;
                    end
                    else
                    begin
                        piece_next = s_rdata;
                        sc_next    = sc_reg - SCNT_W'(1);
                    end
                end
                CMD_SWAP:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_QUEUE_EMPTY;
                    end
                    else if (sc_reg == '0)
                    begin
                        status_next = ST_STACK_EMPTY;
                    end
                    else
                    begin
                        q_we    = 1'b1;
                        q_waddr = head_reg;
                        q_wdata = s_rdata;
                        s_we    = 1'b1;
                        s_waddr = SIDX_W'(sc_reg - SCNT_W'(1));
                        s_wdata = q_rdata;
                    end
                end
                CMD_UNDO:
                begin
                    if (!undo_valid_reg)
                    begin
                        status_next = ST_NO_UNDO;
                    end
                    else if (count_reg == QFULL)
                    begin
                        status_next = ST_QUEUE_FULL;
                    end
                    else
                    begin
                        head_next       = (head_reg == '0) ? QLAST : head_reg - QIDX_W'(1);
                        q_we            = 1'b1;
                        q_waddr         = head_next;
                        q_wdata         = undo_entry_reg;
                        count_next      = count_reg + QCNT_W'(1);
                        piece_next      = undo_entry_reg;
                        undo_valid_next = 1'b0;
                    end
                end
                CMD_INSERT:
                begin
                    if (count_reg == QFULL)
                    begin
                        status_next = ST_QUEUE_FULL;
                    end
                    else
                    begin
                        q_we       = 1'b1;
                        q_waddr    = slot(head_reg, count_reg);
                        count_next = count_reg + QCNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        // reversal: one pair per pass; near read, far moved to near, near written to far
        if (ctl.rev_xfer)
        begin
            q_we    = q_act;
            q_waddr = slot(head_reg, QCNT_W'(pair_reg));
            q_wdata = q_rdata;
            s_we    = s_act;
            s_waddr = SIDX_W'(pair_reg);
            s_wdata = s_rdata;
        end

        if (ctl.rev_wr)
        begin
            q_we      = q_act;
            q_waddr   = slot(head_reg, q_far);
            q_wdata   = tq_reg;
            s_we      = s_act;
            s_waddr   = SIDX_W'(s_far);
            s_wdata   = ts_reg;
            pair_next = pair_reg + PAIR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            count_reg      <= '0;
            sc_reg         <= '0;
            undo_valid_reg <= 1'b0;
            pair_reg       <= '0;
        end
        else
        begin
            head_reg       <= head_next;
            count_reg      <= count_next;
            sc_reg         <= sc_next;
            undo_valid_reg <= undo_valid_next;
            pair_reg       <= pair_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_waddr] <= q_wdata;
        end
        if (s_we)
        begin
            s_mem[s_waddr] <= s_wdata;
        end
        if (ctl.load_in)
        begin
            cmd_reg        <= cmd_t'(command);
            fresh_reg.kind <= new_kind;
            fresh_reg.id   <= new_id;
        end
        if (ctl.rev_rd)
        begin
            tq_reg <= q_rdata;
            ts_reg <= s_rdata;
        end
        undo_entry_reg <= undo_entry_next;
        status_reg     <= status_next;
        piece_reg      <= piece_next;
        if (ctl.load_out)
        begin
            status_out_reg <= status_reg;
            piece_out_reg  <= piece_reg;
            qlvl_out_reg   <= QLVL_W'(count_reg);
            slvl_out_reg   <= SLVL_W'(sc_reg);
            undo_out_reg   <= undo_valid_reg;
        end
    end

    assign status      = status_out_reg;
    assign piece_kind  = piece_out_reg.kind;
    assign piece_id    = piece_out_reg.id;
    assign queue_level = qlvl_out_reg;
    assign stack_level = slvl_out_reg;
    assign undo_ready  = undo_out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= QFULL) && (sc_reg <= SFULL))
        else $error("queue or stack level out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= QLAST)
        else $error("queue head out of range");

    // only a play can arm the undo record
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(undo_valid_reg) |-> ($past(ctl.exec) && ($past(cmd_reg) == CMD_PLAY)))
        else $error("undo record armed by a command other than play");

    // levels never move while a reversal is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.rev_rd || ctl.rev_xfer || ctl.rev_wr) |=>
            ($stable(count_reg) && $stable(sc_reg) && $stable(head_reg)))
        else $error("levels changed during reversal");

endmodule

[src/piece_queue_with_reserve_stack.sv]
// channel   signals                                          direction
// command   in_valid, in_ready, command, new_kind, new_id    in
// result    out_valid, out_ready, status, piece_kind,        out
//           piece_id, queue_level, stack_level, undo_ready
//
// each command steps through transfer in, execute and result load
// reverse adds a read, move, write back and re-check per swapped pair,
//   pairs = max(queue/2, stack/2), set by the single read port on each store
// a finished result waits in the output register while the next transfer in is taken
// reset clears levels, head, undo flag and handshakes; stores are not cleared
// piece_queue_with_reserve_stack: top level, ties pqrs_ctrl to pqrs_dp
// depends on pqrs_pkg, pqrs_ctrl, pqrs_dp
`timescale 1ns / 1ps

module piece_queue_with_reserve_stack
    import pqrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    command,
    input  logic [KIND_W-1:0]   new_kind,
    input  logic [ID_W-1:0]     new_id,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [KIND_W-1:0]   piece_kind,
    output logic [ID_W-1:0]     piece_id,
    output logic [QLVL_W-1:0]   queue_level,
    output logic [SLVL_W-1:0]   stack_level,
    output logic                undo_ready
);

    ctrl_cmd_t  ctl;
    dp_status_t dst;

    pqrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dst       (dst),
        .ctl       (ctl)
    );

    pqrs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (command),
        .new_kind    (new_kind),
        .new_id      (new_id),
        .ctl         (ctl),
        .dst         (dst),
        .status      (status),
        .piece_kind  (piece_kind),
        .piece_id    (piece_id),
        .queue_level (queue_level),
        .stack_level (stack_level),
        .undo_ready  (undo_ready)
    );

endmodule
